// ===== sv/mpq_pkg.sv =====
// types, codes and helpers shared by the priority queue cells and top level
package mpq_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int PRIO_W       = 16;
    localparam int TAG_W        = 32;
    localparam int STATUS_W     = 2;
    localparam int OCC_W        = 5;

    // sort key of an entry that can never be popped: above every positive priority
    localparam logic [PRIO_W-1:0] KEY_NONE = {1'b1, {(PRIO_W-1){1'b0}}};

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_POP    = 1'b1
    } t_command;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE = 2'd0,
        ST_FULL = 2'd1,
        ST_NONE = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_POP    = 2'd2
    } t_cell_op;

    typedef struct packed {
        logic                     command;
        logic signed [PRIO_W-1:0] priority_req;
        logic [TAG_W-1:0]         tag;
    } t_cmd;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [PRIO_W-1:0] popped_priority;
        logic [TAG_W-1:0]         popped_tag;
        logic [OCC_W-1:0]         occupancy;
    } t_rsp;

    typedef struct packed {
        logic                     valid;
        logic signed [PRIO_W-1:0] prio;
        logic [TAG_W-1:0]         tag;
    } t_slot;

    typedef struct packed {
        t_cell_op                 op;
        logic [PRIO_W-1:0]        new_key;
        logic signed [PRIO_W-1:0] new_prio;
        logic [TAG_W-1:0]         new_tag;
    } t_cell_ctl;

    // positive priorities sort by value, zero and below go to the tail
    function automatic logic [PRIO_W-1:0] slot_key(input logic signed [PRIO_W-1:0] p);
        logic positive;
        positive = !p[PRIO_W-1] && (p != '0);
        return positive ? {1'b0, p[PRIO_W-2:0]} : KEY_NONE;
    endfunction

endpackage

// ===== sv/mpq_cell.sv =====
// one cell of the sorted shift chain: holds a single entry
module mpq_cell
    import mpq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_slot     i_prev,
    input  logic      i_prev_stays,
    input  t_slot     i_next,
    output t_slot     o_slot,
    output logic      o_stays
);

    logic                     r_valid;
    logic signed [PRIO_W-1:0] r_prio;
    logic [TAG_W-1:0]         r_tag;

    // equal keys stay ahead of the new entry, so older ones pop first
    assign o_stays = r_valid && (slot_key(r_prio) <= i_ctl.new_key);
    assign o_slot  = '{valid: r_valid, prio: r_prio, tag: r_tag};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            unique case (i_ctl.op)
                OP_INSERT: begin
                    if (!o_stays) begin
                        r_valid <= i_prev_stays ? 1'b1 : i_prev.valid;
                    end
                end
                OP_POP: begin
                    r_valid <= i_next.valid;
                end
                default: begin
                    r_valid <= r_valid;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_ctl.op)
            OP_INSERT: begin
                if (!o_stays) begin
                    if (i_prev_stays) begin
                        r_prio <= i_ctl.new_prio;
                        r_tag  <= i_ctl.new_tag;
                    end else begin
                        r_prio <= i_prev.prio;
                        r_tag  <= i_prev.tag;
                    end
                end
            end
            OP_POP: begin
                r_prio <= i_next.prio;
                r_tag  <= i_next.tag;
            end
            default: begin
                r_prio <= r_prio;
                r_tag  <= r_tag;
            end
        endcase
    end

endmodule

// ===== sv/min_priority_queue_core.sv =====
// bounded min-first priority queue built as a sorted chain of cells
//
// Usage: drive i_cmd and raise start; the item is taken on an edge where
// start is high and busy is low. An insert places (priority, tag) in the
// chain; a pop removes the entry of lowest positive priority, the oldest
// among equals. Entries of priority zero or below are held but never popped.
// Each item gives exactly one result on o_rsp, marked by o_strobe for one
// cycle; the receiver cannot stall, so it must take the result then.
// The accepting edge registers the command and raises busy. Then every
// cell compares the broadcast key with its own and shifts, at the same
// edge that registers the result and raises o_strobe. busy is high for
// one cycle, while the single broadcast-and-shift step of the cell chain
// runs, so no new item is taken before the last one is through.
// Reset (i_rst_n low, synchronous) empties the queue, clears the strobe and
// busy; entry payloads are not cleared and need no clearing pass.
// Occupancy is reported as its low five bits.
module min_priority_queue_core
    import mpq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_cmd i_cmd,
    output logic busy,
    output logic o_strobe,
    output t_rsp o_rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic             r_exec;
    t_cmd             r_cmd;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_strobe;
    t_rsp             r_rsp;
    t_rsp             n_rsp;
    t_cell_ctl        w_ctl;

    t_slot w_slot  [CAPACITY];
    logic  w_stays [CAPACITY];

    logic w_full;
    logic w_head_ok;

    assign busy     = r_exec;
    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

    assign w_full    = (r_count == CNT_W'(CAPACITY));
    assign w_head_ok = w_slot[0].valid && (slot_key(w_slot[0].prio) != KEY_NONE);

    always_comb begin
        w_ctl.op       = OP_HOLD;
        w_ctl.new_key  = slot_key(r_cmd.priority_req);
        w_ctl.new_prio = r_cmd.priority_req;
        w_ctl.new_tag  = r_cmd.tag;
        n_count        = r_count;
        n_rsp.status          = ST_DONE;
        n_rsp.popped_priority = '0;
        n_rsp.popped_tag      = '0;
        if (r_exec) begin
            unique case (t_command'(r_cmd.command))
                CMD_INSERT: begin
                    if (w_full) begin
                        n_rsp.status = ST_FULL;
                    end else begin
                        w_ctl.op = OP_INSERT;
                        n_count  = r_count + 1'b1;
                    end
                end
                CMD_POP: begin
                    // chain is sorted, so only the head can be eligible
                    if (w_head_ok) begin
                        w_ctl.op              = OP_POP;
                        n_count               = r_count - 1'b1;
                        n_rsp.popped_priority = w_slot[0].prio;
                        n_rsp.popped_tag      = w_slot[0].tag;
                    end else begin
                        n_rsp.status = ST_NONE;
                    end
                end
                default: begin
                    n_rsp.status = ST_DONE;
                end
            endcase
        end
        n_rsp.occupancy = OCC_W'(n_count);
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            t_slot w_prev;
            t_slot w_next;
            logic  w_prev_stays;
            if (gi == 0) begin : g_head
                assign w_prev       = '0;
                assign w_prev_stays = 1'b1;
            end else begin : g_body
                assign w_prev       = w_slot[gi-1];
                assign w_prev_stays = w_stays[gi-1];
            end
            if (gi == CAPACITY - 1) begin : g_tail
                assign w_next = '0;
            end else begin : g_inner
                assign w_next = w_slot[gi+1];
            end
            mpq_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (w_ctl),
                .i_prev       (w_prev),
                .i_prev_stays (w_prev_stays),
                .i_next       (w_next),
                .o_slot       (w_slot[gi]),
                .o_stays      (w_stays[gi])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exec   <= 1'b0;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_exec   <= start && !r_exec;
            r_count  <= n_count;
            r_strobe <= r_exec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !r_exec) begin
            r_cmd <= i_cmd;
        end
        if (r_exec) begin
            r_rsp <= n_rsp;
        end
    end

    a_strobe_follows_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> $past(r_exec))
        else $error("result strobe without an item in execution");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("occupancy above capacity");

    a_head_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_slot[0].valid == (r_count != '0))
        else $error("head cell validity disagrees with occupancy");

    a_full_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && (r_rsp.status == ST_FULL)) |-> (r_count == CNT_W'(CAPACITY)))
        else $error("insert refused while space remained");

endmodule

// ===== tb/sv/tb_min_priority_queue_core.sv =====
// testbench for the min-first priority queue: directed and random commands against a slot-based predictor
`timescale 1ns / 100ps

module tb_min_priority_queue_core;
    import mpq_pkg::*;

    localparam int DEPTH        = CAPACITY_DEF;
    localparam int RANDOM_ITEMS = 850;
    localparam int DRAIN_CYCLES = 10;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_cmd i_cmd   = '0;
    logic busy;
    logic o_strobe;
    t_rsp o_rsp;

    min_priority_queue_core #(
        .CAPACITY (DEPTH)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cmd    (i_cmd),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_rsp    (o_rsp)
    );

    always #1 i_clk = ~i_clk;

    // predictor copy of the queue contents
    logic signed [PRIO_W-1:0] held_prio [DEPTH];
    logic [TAG_W-1:0]         held_tag  [DEPTH];
    logic                     held_used [DEPTH];
    logic [31:0]              held_age  [DEPTH];
    logic [31:0]              insert_count;

    t_cmd pending_items [$];
    t_rsp expected_rsp [$];
    int   n_mismatch = 0;

    // occupancy tracking used only to steer the generator
    int gen_pos    = 0;
    int gen_nonpos = 0;

    function automatic t_rsp queue_step(input t_cmd c);
        t_rsp                     r;
        int                       i;
        int                       free_idx;
        int                       best;
        int                       held;
        logic [31:0]              d;
        logic [31:0]              best_d;
        logic signed [PRIO_W-1:0] best_p;
        r        = '0;
        r.status = ST_DONE;
        free_idx = -1;
        best     = -1;
        held     = 0;
        best_d   = '0;
        best_p   = '0;
        if (c.command == CMD_INSERT) begin
            for (i = 0; i < DEPTH; i++)
                if (!held_used[i] && free_idx < 0)
                    free_idx = i;
            if (free_idx < 0) begin
                r.status = ST_FULL;
            end else begin
                held_prio[free_idx] = c.priority_req;
                held_tag[free_idx]  = c.tag;
                held_age[free_idx]  = insert_count;
                held_used[free_idx] = 1'b1;
                insert_count        = insert_count + 32'd1;
            end
        end else begin
            for (i = 0; i < DEPTH; i++) begin
                if (held_used[i] && held_prio[i] > 0) begin
                    // older entries sit further behind the insert count
                    d = insert_count - held_age[i];
                    if (best < 0 || held_prio[i] < best_p ||
                            (held_prio[i] == best_p && d > best_d)) begin
                        best   = i;
                        best_p = held_prio[i];
                        best_d = d;
                    end
                end
            end
            if (best < 0) begin
                r.status = ST_NONE;
            end else begin
                r.popped_priority = held_prio[best];
                r.popped_tag      = held_tag[best];
                held_used[best]   = 1'b0;
            end
        end
        for (i = 0; i < DEPTH; i++)
            if (held_used[i])
                held++;
        r.occupancy = held[OCC_W-1:0];
        return r;
    endfunction

    task automatic add_item(input logic cmd, input logic [PRIO_W-1:0] prio,
                            input logic [TAG_W-1:0] tag);
        t_cmd c;
        c.command      = cmd;
        c.priority_req = prio;
        c.tag          = tag;
        pending_items  = {pending_items, c};
        if (cmd == CMD_INSERT) begin
            if (gen_pos + gen_nonpos < DEPTH) begin
                if ($signed(prio) > 0)
                    gen_pos++;
                else
                    gen_nonpos++;
            end
        end else if (gen_pos > 0) begin
            gen_pos--;
        end
    endtask

    // driver: bursts of items separated by random gaps
    int   burst_left = 1;
    int   gap_left   = 0;
    logic nxt_start;
    t_cmd nxt_cmd;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            i_cmd <= '0;
        end else begin
            if (start && !busy)
                expected_rsp = {expected_rsp, queue_step(i_cmd)};
            // an item still waiting on busy is held as it is
            if (!(start && busy)) begin
                nxt_start = 1'b0;
                nxt_cmd   = t_cmd'({$urandom, $urandom});
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_items.size() > 0) begin
                    nxt_cmd   = pending_items.pop_front();
                    nxt_start = 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 16);
                        case ($urandom_range(0, 9))
                            0, 1, 2:       gap_left = 0;
                            3, 4, 5, 6, 7: gap_left = $urandom_range(1, 3);
                            default:       gap_left = $urandom_range(4, 12);
                        endcase
                    end
                end
                start <= nxt_start;
                i_cmd <= nxt_cmd;
            end
        end
    end

    // monitor: every strobe is checked against the oldest expected response
    t_rsp want;

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (expected_rsp.size() == 0) begin
                if (n_mismatch < 10)
                    $display("unexpected response: status %0d prio %0d tag %h occ %0d",
                             o_rsp.status, o_rsp.popped_priority, o_rsp.popped_tag,
                             o_rsp.occupancy);
                n_mismatch++;
            end else begin
                want = expected_rsp.pop_front();
                if (o_rsp.status != want.status ||
                        o_rsp.popped_priority != want.popped_priority ||
                        o_rsp.popped_tag != want.popped_tag ||
                        o_rsp.occupancy != want.occupancy) begin
                    if (n_mismatch < 10) begin
                        $display("mismatch: exp status %0d prio %0d tag %h occ %0d",
                                 want.status, want.popped_priority, want.popped_tag,
                                 want.occupancy);
                        $display("          got status %0d prio %0d tag %h occ %0d",
                                 o_rsp.status, o_rsp.popped_priority,
                                 o_rsp.popped_tag, o_rsp.occupancy);
                    end
                    n_mismatch++;
                end
            end
        end
    end

    initial begin
        #400000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        int                       n;
        int                       insert_pct;
        logic [PRIO_W-1:0]        prio;
        logic [TAG_W-1:0]         tag;
        for (n = 0; n < DEPTH; n++) begin
            held_used[n] = 1'b0;
            held_prio[n] = '0;
            held_tag[n]  = '0;
            held_age[n]  = '0;
        end
        insert_count = '0;
        insert_pct   = 50;

        // directed: empty pop, unpoppable entries, ties, duplicates, full queue
        add_item(CMD_POP, 16'sd7, 32'h1234_5678);
        add_item(CMD_INSERT, 16'sd0, 32'h0000_0010);
        add_item(CMD_INSERT, 16'sh8000, 32'hffff_ffff);
        add_item(CMD_INSERT, -16'sd1, 32'h0000_0011);
        add_item(CMD_POP, '1, '1);
        add_item(CMD_INSERT, 16'sd32767, 32'hffff_ffff);
        add_item(CMD_INSERT, 16'sd1, 32'h0000_0000);
        add_item(CMD_INSERT, 16'sd1, 32'h0000_0001);
        add_item(CMD_INSERT, 16'sd5, 32'h5555_aaaa);
        add_item(CMD_INSERT, 16'sd5, 32'h5555_aaaa);
        for (n = 0; n < 8; n++)
            add_item(CMD_INSERT, 16'(100 + n), $urandom);
        add_item(CMD_INSERT, 16'sd2, 32'hdead_0002);
        for (n = 0; n < 6; n++)
            add_item(CMD_POP, 16'($urandom), $urandom);

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            // swing between filling, balanced and draining phases
            if (n % 60 == 0)
                case ($urandom_range(0, 2))
                    0:       insert_pct = 15;
                    1:       insert_pct = 50;
                    default: insert_pct = 85;
                endcase
            if ($urandom_range(0, 99) < insert_pct) begin
                // zero and negative entries never leave, so keep them few
                if (gen_pos + gen_nonpos == DEPTH && $urandom_range(0, 9) < 3)
                    prio = 16'($urandom_range(32768, 65536));
                else if (gen_nonpos < 6 && $urandom_range(0, 99) < 3)
                    prio = 16'($urandom_range(32768, 65536));
                else
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4, 5: prio = 16'($urandom_range(1, 8));
                        6, 7:             prio = 16'($urandom_range(1, 32767));
                        8:                prio = $urandom_range(0, 1) ? 16'sd32767 : 16'sd1;
                        default:          prio = 16'($urandom_range(1, 300));
                    endcase
                tag = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 3)) : $urandom;
                add_item(CMD_INSERT, prio, tag);
            end else begin
                add_item(CMD_POP, 16'($urandom), $urandom);
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sample between edges so the driver's updates have settled
        while (pending_items.size() > 0 || start)
            @(negedge i_clk);
        while (expected_rsp.size() > 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (n_mismatch == 0 && expected_rsp.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
